// ----- rtl/core/arcp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package arcp_pkg;

  localparam int unsigned MAX_PER_PACKET_DEF = 32768;
  localparam int unsigned GAP_LIMIT_DEF      = 262144;

  localparam int unsigned CFG_ADDR_W    = 4;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned BYTES_PER_MS  = 192;
  localparam int unsigned LEAD_COUNT    = 5;
  localparam int unsigned DEFAULT_LEAD  = 64;
  localparam logic [2:0]  RESERVE_RESET = 3'd3;

  localparam logic [7:0] LEAD_MS [LEAD_COUNT] = '{8'd0, 8'd16, 8'd32, 8'd64, 8'd128};

  typedef enum logic [1:0] {
    REG_AUDIO_ENABLE    = 2'd0,
    REG_BYTES_PER_FIELD = 2'd1,
    REG_RESERVE_SELECT  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    PRIME_NONE  = 2'd0,
    PRIME_READY = 2'd1,
    PRIME_CLOCK = 2'd2,
    PRIME_GAP   = 2'd3
  } prime_code_t;

  typedef struct packed {
    logic              audio_enable;
    logic [31:0]       bytes_per_field;
    logic [2:0]        reserve_select;
  } cfg_t;

  typedef struct packed {
    logic              link_up;
    logic              restart;
    logic [31:0]       display_count;
    logic              display_audio_on;
    logic signed [31:0] budget_position;
    logic [19:0]       bytes_buffered;
  } in_item_t;

  typedef struct packed {
    logic              active;
    prime_code_t       prime_code;
    logic [63:0]       product;
    logic signed [31:0] budget_position;
    logic [19:0]       bytes_buffered;
  } credit_t;

  typedef struct packed {
    logic [30:0]       played_bytes;
    logic [15:0]       silence_bytes;
    logic [15:0]       data_bytes;
    logic              send_valid;
    prime_code_t       prime_code;
  } out_item_t;

  function automatic logic [14:0] reserve_bytes(input logic [2:0] sel);
    logic [7:0] ms;
    ms = (sel < 3'(LEAD_COUNT)) ? LEAD_MS[sel] : 8'(DEFAULT_LEAD);
    return 15'(ms * BYTES_PER_MS);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/arcp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface arcp_in_if;
  logic              valid;
  logic              ready;
  logic              link_up;
  logic              restart;
  logic [31:0]       display_count;
  logic              display_audio_on;
  logic signed [31:0] budget_position;
  logic [19:0]       bytes_buffered;

  modport source (
    output valid, link_up, restart, display_count, display_audio_on,
           budget_position, bytes_buffered,
    input  ready
  );
  modport sink (
    input  valid, link_up, restart, display_count, display_audio_on,
           budget_position, bytes_buffered,
    output ready
  );
endinterface

interface arcp_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] played_bytes;
  logic [15:0] silence_bytes;
  logic [15:0] data_bytes;
  logic        send_valid;
  logic [1:0]  prime_code;

  modport source (
    output valid, played_bytes, silence_bytes, data_bytes, send_valid, prime_code,
    input  ready
  );
  modport sink (
    input  valid, played_bytes, silence_bytes, data_bytes, send_valid, prime_code,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/arcp_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module arcp_cfg (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [arcp_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire logic [arcp_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic      [arcp_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                       pready,
  output arcp_pkg::cfg_t                             cfg
);

  arcp_pkg::cfg_t cfg_r;
  arcp_pkg::reg_index_t idx;
  logic wr_en;

  always_comb begin
    idx   = arcp_pkg::reg_index_t'(paddr[3:2]);
    wr_en = psel & penable & pwrite;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.audio_enable    <= 1'b0;
      cfg_r.bytes_per_field <= '0;
      cfg_r.reserve_select  <= arcp_pkg::RESERVE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        arcp_pkg::REG_AUDIO_ENABLE:    cfg_r.audio_enable    <= pwdata[0];
        arcp_pkg::REG_BYTES_PER_FIELD: cfg_r.bytes_per_field <= pwdata;
        arcp_pkg::REG_RESERVE_SELECT:  cfg_r.reserve_select  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      arcp_pkg::REG_AUDIO_ENABLE:    prdata = {31'b0, cfg_r.audio_enable};
      arcp_pkg::REG_BYTES_PER_FIELD: prdata = cfg_r.bytes_per_field;
      arcp_pkg::REG_RESERVE_SELECT:  prdata = {29'b0, cfg_r.reserve_select};
      default:                       prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/core/arcp_credit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module arcp_credit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire arcp_pkg::cfg_t     cfg,
  input  wire logic               s1_v,
  input  wire arcp_pkg::in_item_t s1,
  output logic                    s1_ready,
  output logic                    s2_v,
  output arcp_pkg::credit_t       s2,
  input  wire logic               s2_ready
);

  logic              primed_r, primed_nxt;
  logic [31:0]       last_count_r, last_count_nxt;
  logic              s2_v_r;
  arcp_pkg::credit_t s2_r, s2_nxt;
  logic              primed_eff, path_on, active, reprime, adv;
  logic [31:0]       delta;

  always_comb begin
    primed_eff = primed_r & ~s1.restart;
    path_on    = cfg.audio_enable & s1.link_up;
    active     = path_on & s1.display_audio_on;
    reprime    = !primed_eff || (s1.display_count < last_count_r);
    delta      = s1.display_count - last_count_r;

    primed_nxt     = primed_eff;
    last_count_nxt = last_count_r;
    if (path_on) begin
      primed_nxt = s1.display_audio_on;
      if (active) begin
        last_count_nxt = s1.display_count;
      end
    end

    s2_nxt.active          = active;
    s2_nxt.prime_code      = (!active || !reprime) ? arcp_pkg::PRIME_NONE :
                             (primed_eff ? arcp_pkg::PRIME_CLOCK : arcp_pkg::PRIME_READY);
    s2_nxt.product         = 64'(delta) * 64'(cfg.bytes_per_field);
    s2_nxt.budget_position = s1.budget_position;
    s2_nxt.bytes_buffered  = s1.bytes_buffered;
  end

  assign s1_ready = !s2_v_r || s2_ready;
  assign adv      = s1_v & s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r     <= 1'b0;
      last_count_r <= '0;
      s2_v_r       <= 1'b0;
    end else begin
      if (s1_ready) begin
        s2_v_r <= s1_v;
      end
      if (adv) begin
        primed_r     <= primed_nxt;
        last_count_r <= last_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_v = s2_v_r;
  assign s2   = s2_r;

`ifndef ASSERT_OFF
  a_active_leaves_primed: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && active) |=> primed_r)
    else $error("credit stage did not leave the block primed after an active frame");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/arcp_pace.sv -----
`timescale 1ns / 1ps
`default_nettype none

module arcp_pace #(
  parameter int unsigned MAX_PER_PACKET = arcp_pkg::MAX_PER_PACKET_DEF,
  parameter int unsigned GAP_LIMIT      = arcp_pkg::GAP_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire arcp_pkg::cfg_t    cfg,
  input  wire logic              s2_v,
  input  wire arcp_pkg::credit_t s2,
  output logic                   s2_ready,
  output logic                   out_v,
  output arcp_pkg::out_item_t    out_item,
  input  wire logic              out_ready
);

  localparam logic [15:0]        MAX_PKT = 16'(MAX_PER_PACKET);
  localparam logic signed [63:0] GAP_LIM = 64'(GAP_LIMIT);

  logic [15:0]          carry_r, carry_nxt;
  logic [63:0]          diff_r, diff_nxt;
  logic                 out_v_r;
  arcp_pkg::out_item_t  out_r, out_nxt;
  logic                 adv, reprime;
  logic [63:0]          due, diff_a, owed;
  logic [47:0]          whole;
  logic [15:0]          carry_a;
  logic [30:0]          played;
  logic                 owed_pos, gap_over, send;
  logic signed [33:0]   gap_n, shortfall, want;
  logic [15:0]          field, cap, sil_raw, sil, room, avail_raw, avail;
  logic [16:0]          total;

  always_comb begin
    reprime = (s2.prime_code != arcp_pkg::PRIME_NONE);
    due     = 64'(carry_r) + s2.product;
    whole   = due[63:16];
    if (reprime) begin
      carry_a = '0;
      diff_a  = '0;
      played  = '0;
    end else begin
      carry_a = due[15:0];
      diff_a  = diff_r + 64'(whole);
      played  = (|whole[47:31]) ? '1 : whole[30:0];
    end

    owed     = diff_a + 64'(arcp_pkg::reserve_bytes(cfg.reserve_select));
    owed_pos = !owed[63] && (|owed);
    gap_over = $signed(diff_a) > GAP_LIM;

    field     = cfg.bytes_per_field[31:16];
    gap_n     = $signed(diff_a[33:0]);
    shortfall = -34'(s2.budget_position) - $signed({18'b0, field});
    want      = (gap_n > shortfall) ? gap_n : shortfall;
    cap       = (owed < 64'(MAX_PKT)) ? owed[15:0] : MAX_PKT;

    if (want <= 34'sd0) begin
      sil_raw = '0;
    end else if (want > $signed({18'b0, cap})) begin
      sil_raw = cap;
    end else begin
      sil_raw = want[15:0];
    end
    sil  = {sil_raw[15:2], 2'b00};
    room = cap - sil;

    avail_raw = (s2.bytes_buffered < {4'b0, room}) ? s2.bytes_buffered[15:0] : room;
    avail     = {avail_raw[15:2], 2'b00};
    total     = 17'(sil) + 17'(avail);
    send      = |total;

    carry_nxt = carry_r;
    diff_nxt  = diff_r;
    out_nxt   = '0;
    if (s2.active) begin
      carry_nxt          = carry_a;
      diff_nxt           = diff_a;
      out_nxt.played_bytes = played;
      out_nxt.prime_code   = s2.prime_code;
      if (owed_pos) begin
        if (gap_over) begin
          out_nxt.prime_code = arcp_pkg::PRIME_GAP;
          carry_nxt          = '0;
          diff_nxt           = '0;
        end else if (send) begin
          diff_nxt              = diff_a - 64'(total);
          out_nxt.silence_bytes = sil;
          out_nxt.data_bytes    = avail;
          out_nxt.send_valid    = 1'b1;
        end
      end
    end
  end

  assign s2_ready = !out_v_r || out_ready;
  assign adv      = s2_v & s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      carry_r <= '0;
      diff_r  <= '0;
    end else begin
      if (s2_ready) begin
        out_v_r <= s2_v;
      end
      if (adv) begin
        carry_r <= carry_nxt;
        diff_r  <= diff_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_v    = out_v_r;
  assign out_item = out_r;

`ifndef ASSERT_OFF
  a_send_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.send_valid) |->
      (out_r.silence_bytes[1:0] == 2'b00 && out_r.data_bytes[1:0] == 2'b00 &&
       (out_r.silence_bytes != 16'd0 || out_r.data_bytes != 16'd0)))
    else $error("packet sizes are not whole words or the packet is empty");

  a_packet_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (17'(out_r.silence_bytes) + 17'(out_r.data_bytes) <= 17'(MAX_PKT)))
    else $error("packet exceeds the per-packet limit");

  a_gap_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.prime_code == arcp_pkg::PRIME_GAP) |->
      (!out_r.send_valid && out_r.silence_bytes == 16'd0 && out_r.data_bytes == 16'd0))
    else $error("a gap reset transaction also carries a packet");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/audio_reserve_credit_pacer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Once per video frame this block takes the display's acknowledged field count and
// returns one transaction with the bytes credited as played, the silence and data
// bytes to send, and a priming code. An item passes through three registers (input,
// credit with its 32 by 32 multiply, and pacing/result). A new item is taken every
// cycle unless out_chan.ready holds the output back; the rate is one item per cycle,
// set by the state update in each of the two working stages. Configuration must be
// written through the APB port only while no item is in flight, a rule for the user
// that the block itself does not enforce; addresses 0, 4 and 8 hold audio enable,
// bytes per field (Q16.16) and the reserve selection.
module audio_reserve_credit_pacer #(
  parameter int unsigned MAX_PER_PACKET = arcp_pkg::MAX_PER_PACKET_DEF,
  parameter int unsigned GAP_LIMIT      = arcp_pkg::GAP_LIMIT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  arcp_in_if.sink                              in_chan,
  arcp_out_if.source                           out_chan,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [arcp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [arcp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [arcp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  arcp_pkg::cfg_t      cfg;
  arcp_pkg::in_item_t  in_item, s1_r;
  logic                s1_v_r, s1_ready, in_ready;
  logic                s2_v, s2_ready, out_v;
  arcp_pkg::credit_t   s2;
  arcp_pkg::out_item_t out_item;

  arcp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    in_item.link_up          = in_chan.link_up;
    in_item.restart          = in_chan.restart;
    in_item.display_count    = in_chan.display_count;
    in_item.display_audio_on = in_chan.display_audio_on;
    in_item.budget_position  = in_chan.budget_position;
    in_item.bytes_buffered   = in_chan.bytes_buffered;
  end

  assign in_ready      = !s1_v_r || s1_ready;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      s1_r <= in_item;
    end
  end

  arcp_credit u_credit (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_v     (s1_v_r),
    .s1       (s1_r),
    .s1_ready (s1_ready),
    .s2_v     (s2_v),
    .s2       (s2),
    .s2_ready (s2_ready)
  );

  arcp_pace #(
    .MAX_PER_PACKET (MAX_PER_PACKET),
    .GAP_LIMIT      (GAP_LIMIT)
  ) u_pace (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s2_v      (s2_v),
    .s2        (s2),
    .s2_ready  (s2_ready),
    .out_v     (out_v),
    .out_item  (out_item),
    .out_ready (out_chan.ready)
  );

  always_comb begin
    out_chan.valid         = out_v;
    out_chan.played_bytes  = out_item.played_bytes;
    out_chan.silence_bytes = out_item.silence_bytes;
    out_chan.data_bytes    = out_item.data_bytes;
    out_chan.send_valid    = out_item.send_valid;
    out_chan.prime_code    = out_item.prime_code;
  end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import arcp_pkg::*;

  localparam int unsigned RUN_LIMIT  = 200000;
  localparam int unsigned PIPE_DEPTH = 3;
  localparam longint      PACKET_MAX = MAX_PER_PACKET_DEF;
  localparam longint      GAP_MAX    = GAP_LIMIT_DEF;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;

  arcp_in_if  in_chan ();
  arcp_out_if out_chan ();

  audio_reserve_credit_pacer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Register copies as the block should hold them.
  bit          audio_en   = 1'b0;
  logic [31:0] field_rate = '0;
  logic [2:0]  lead_sel   = RESERVE_RESET;

  // Tracking state of the display's playback position.
  bit          sync_primed = 1'b0;
  logic [31:0] sync_count  = '0;
  logic [15:0] sync_carry  = '0;
  logic [63:0] played_sum  = '0;
  logic [63:0] sent_sum    = '0;

  out_item_t   pending_reports[$];
  int          faults      = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;
  logic [31:0] field_clock = '0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_chan.ready = steady || ($urandom_range(0, 99) >= 15);
  end

  function automatic longint lead_bytes();
    longint ms;
    case (lead_sel)
      3'd0: ms = 0;
      3'd1: ms = 16;
      3'd2: ms = 32;
      3'd4: ms = 128;
      default: ms = 64;
    endcase
    return ms * 192;
  endfunction

  function automatic void reprime(input logic [31:0] count);
    sync_count  = count;
    sync_carry  = '0;
    played_sum  = '0;
    sent_sum    = '0;
    sync_primed = 1'b1;
  endfunction

  function automatic out_item_t pace_frame(input in_item_t it);
    out_item_t   res;
    logic [31:0] delta;
    logic [63:0] due;
    logic [63:0] whole;
    logic [63:0] gap_raw;
    longint      gap;
    longint      owed;
    longint      shortfall;
    longint      silence;
    longint      cap;
    longint      room;
    longint      avail;
    res = '0;
    res.prime_code = PRIME_NONE;
    if (it.restart)
      sync_primed = 1'b0;
    if (audio_en && it.link_up) begin
      if (!it.display_audio_on) begin
        sync_primed = 1'b0;
      end else begin
        if (!sync_primed || it.display_count < sync_count) begin
          res.prime_code = sync_primed ? PRIME_CLOCK : PRIME_READY;
          reprime(it.display_count);
        end else begin
          delta = it.display_count - sync_count;
          due = {48'd0, sync_carry} + {32'd0, delta} * {32'd0, field_rate};
          whole = due >> 16;
          sync_carry = due[15:0];
          sync_count = it.display_count;
          played_sum += whole;
          res.played_bytes = (whole > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : whole[30:0];
        end
        gap_raw = played_sum - sent_sum;
        gap = $signed(gap_raw);
        owed = $signed(gap_raw + 64'(lead_bytes()));
        if (owed > 0) begin
          if (gap > GAP_MAX) begin
            res.prime_code = PRIME_GAP;
            reprime(sync_count);
          end else begin
            shortfall = -longint'($signed(it.budget_position)) - longint'(field_rate >> 16);
            silence = (gap > shortfall) ? gap : shortfall;
            if (silence < 0)
              silence = 0;
            cap = (owed < PACKET_MAX) ? owed : PACKET_MAX;
            if (silence > cap)
              silence = cap;
            silence = silence & ~longint'(3);
            room = cap - silence;
            avail = (longint'(it.bytes_buffered) < room) ? longint'(it.bytes_buffered) : room;
            avail = avail & ~longint'(3);
            if (silence + avail > 0) begin
              sent_sum += 64'(silence + avail);
              res.silence_bytes = 16'(silence);
              res.data_bytes = 16'(avail);
              res.send_valid = 1'b1;
            end
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      faults++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_reports.size() == 0) begin
        faults++;
        $display("%0t ns: transaction with nothing expected, expected none, actual played %0d",
                 $time, out_chan.played_bytes);
      end else begin
        want = pending_reports.pop_front();
        check_field("played_bytes", want.played_bytes, out_chan.played_bytes);
        check_field("silence_bytes", want.silence_bytes, out_chan.silence_bytes);
        check_field("data_bytes", want.data_bytes, out_chan.data_bytes);
        check_field("send_valid", want.send_valid, out_chan.send_valid);
        check_field("prime_code", want.prime_code, out_chan.prime_code);
      end
    end
  end

  task automatic send_frame(input in_item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 15) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid            = 1'b1;
    in_chan.link_up          = it.link_up;
    in_chan.restart          = it.restart;
    in_chan.display_count    = it.display_count;
    in_chan.display_audio_on = it.display_audio_on;
    in_chan.budget_position  = it.budget_position;
    in_chan.bytes_buffered   = it.bytes_buffered;
    do @(posedge clk); while (!in_chan.ready);
    pending_reports.push_back(pace_frame(it));
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_AUDIO_ENABLE:    audio_en = value[0];
      REG_BYTES_PER_FIELD: field_rate = value;
      REG_RESERVE_SELECT:  lead_sel = value[2:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input bit en, input logic [31:0] rate, input logic [2:0] sel);
    drain();
    write_reg(REG_AUDIO_ENABLE, {31'd0, en});
    write_reg(REG_BYTES_PER_FIELD, rate);
    write_reg(REG_RESERVE_SELECT, {29'd0, sel});
  endtask

  function automatic in_item_t mk_frame(input bit link, input bit rs, input logic [31:0] count,
                                        input bit on, input logic [31:0] budget,
                                        input logic [19:0] avail_bytes);
    in_item_t it;
    it.link_up          = link;
    it.restart          = rs;
    it.display_count    = count;
    it.display_audio_on = on;
    it.budget_position  = budget;
    it.bytes_buffered   = avail_bytes;
    return it;
  endfunction

  // Mostly steady playback with a few restarts, dropouts and jumps mixed in.
  function automatic in_item_t random_frame();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.link_up          = 1'b1;
    it.restart          = 1'b0;
    it.display_audio_on = 1'b1;
    field_clock += ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 40);
    if (pick < 78) begin
    end else if (pick < 85) begin
      field_clock = $urandom_range(0, 1) ? field_clock - 32'($urandom_range(1, 1000))
                                         : 32'($urandom());
    end else if (pick < 89) begin
      it.restart = 1'b1;
    end else if (pick < 92) begin
      it.display_audio_on = 1'b0;
    end else if (pick < 95) begin
      it.link_up = 1'b0;
    end else if (pick < 98) begin
      field_clock += $urandom_range(50, 5000);
    end else begin
      it.link_up          = 1'($urandom_range(0, 1));
      it.restart          = 1'($urandom_range(0, 1));
      it.display_audio_on = 1'($urandom_range(0, 1));
    end
    it.display_count = (pick >= 98) ? 32'($urandom()) : field_clock;
    it.budget_position = ($urandom_range(0, 9) == 0) ? 32'($urandom())
                                                     : 32'(int'($urandom_range(0, 60000)) - 30000);
    it.bytes_buffered = ($urandom_range(0, 9) < 3) ? 20'($urandom())
                                                   : 20'($urandom_range(0, 40000));
    return it;
  endfunction

  task automatic test_disabled();
    send_frame(mk_frame(1, 0, 32'h1234_5678, 1, -5, 100));
    send_frame(mk_frame(1, 1, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 20'hFFFFF));
    send_frame(mk_frame(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_priming();
    set_config(1'b1, 32'd3200 << 16, 3'd3);
    send_frame(mk_frame(0, 0, 100, 1, 0, 20'hFFFFF));
    send_frame(mk_frame(1, 0, 100, 0, 0, 20'hFFFFF));
    send_frame(mk_frame(1, 0, 100, 1, 0, 20'hFFFFF));
    send_frame(mk_frame(1, 0, 101, 1, 32'h8000_0000, 0));
    send_frame(mk_frame(1, 0, 101, 1, 32'h7FFF_FFFF, 5));
    send_frame(mk_frame(1, 0, 102, 1, -3000, 3));
    send_frame(mk_frame(1, 0, 50, 1, 0, 1000));
    send_frame(mk_frame(1, 1, 60, 1, 0, 1000));
    send_frame(mk_frame(0, 1, 61, 1, 0, 0));
    send_frame(mk_frame(1, 0, 65, 1, 0, 1000));
  endtask

  task automatic test_gap_and_saturation();
    send_frame(mk_frame(1, 0, 265, 1, 0, 1000));
    send_frame(mk_frame(1, 0, 32'hFFFF_FFFF, 1, 0, 1000));
    send_frame(mk_frame(1, 0, 0, 1, 0, 1000));
    send_frame(mk_frame(1, 0, 1, 1, 0, 1000));
  endtask

  task automatic test_lead_and_fraction();
    set_config(1'b1, 32'h0000_8000, 3'd0);
    send_frame(mk_frame(1, 0, 7, 1, 0, 100));
    send_frame(mk_frame(1, 0, 8, 1, 0, 100));
    send_frame(mk_frame(1, 0, 9, 1, 0, 100));
    set_config(1'b1, 32'hFFFF_FFFF, 3'd7);
    send_frame(mk_frame(1, 0, 10, 1, 0, 20'hFFFFF));
    send_frame(mk_frame(1, 0, 32'hFFFF_FFFE, 1, 0, 0));
    set_config(1'b1, 32'd0, 3'd4);
    send_frame(mk_frame(1, 0, 32'hFFFF_FFFF, 1, 100, 4));
  endtask

  task automatic run_phase(input bit en, input logic [31:0] rate, input logic [2:0] sel,
                           input int count, input bit calm);
    set_config(en, rate, sel);
    steady = calm;
    field_clock = $urandom();
    for (int i = 0; i < count; i++) begin
      // Halfway through, the sender holds off until the pipeline is empty.
      if (i == count / 2)
        drain();
      send_frame(random_frame());
    end
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    run_phase(1'b1, 32'd3200 << 16, 3'd3, 200, 1'b0);
    run_phase(1'b1, 32'h0320_8000, 3'd4, 200, 1'b0);
    run_phase(1'b1, (32'd800 << 16) | 32'h1234, 3'd0, 200, 1'b1);
    run_phase(1'b1, $urandom(), 3'($urandom_range(5, 7)), 150, 1'b0);
    run_phase(1'b1, 32'hFFFF_FFFF, 3'd7, 100, 1'b0);
    run_phase(1'b1, 32'd0, 3'd1, 150, 1'b0);
    run_phase(1'b0, 32'd3200 << 16, 3'd2, 50, 1'b0);
    run_phase(1'b1, (32'd1600 << 16) | 32'hFFFF, 3'($urandom_range(0, 7)), 300, 1'b0);
  endtask

  initial begin
    rst_n                    = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    in_chan.valid            = 1'b0;
    in_chan.link_up          = 1'b0;
    in_chan.restart          = 1'b0;
    in_chan.display_count    = '0;
    in_chan.display_audio_on = 1'b0;
    in_chan.budget_position  = '0;
    in_chan.bytes_buffered   = '0;
    out_chan.ready           = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_disabled();
    test_priming();
    test_gap_and_saturation();
    test_lead_and_fraction();
    test_random_phases();
    drain();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (faults == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/arcp_pkg.sv
rtl/core/arcp_if.sv
rtl/core/arcp_cfg.sv
rtl/core/arcp_credit.sv
rtl/core/arcp_pace.sv
rtl/core/audio_reserve_credit_pacer.sv
sim/tb.sv
